### hw/rtl/srs_pkg.sv
// Shared types, constants and helpers of the sample rate selector.
package srs_pkg;

  localparam int RATE_BITS   = 32;
  localparam int DIV_STAGES  = RATE_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [RATE_BITS-1:0] rate_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FLOOR   = 2'd0,
    CFG_CEILING = 2'd1,
    CFG_STEP    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OUT_IDEAL     = 3'd0,
    OUT_RAISED    = 3'd1,
    OUT_REDUCED   = 3'd2,
    OUT_BELOW_MIN = 3'd3,
    OUT_CAPS_BAD  = 3'd4
  } outcome_t;

  typedef struct packed {
    rate_t target_hz;
    rate_t least_hz;
    rate_t useful_ceiling_hz;
    rate_t preferred_multiple_hz;
  } in_t;

  typedef struct packed {
    rate_t      chosen_hz;
    logic [2:0] outcome;
  } out_t;

  typedef struct packed {
    rate_t      floor_hz;
    rate_t      ceiling_hz;
    rate_t      step_hz;
  } cfg_t;

  // Request state carried down the back end.
  typedef struct packed {
    logic  caps_bad;
    logic  up_ok;
    rate_t ideal;
    rate_t minimum;
    rate_t ceil_use;
    rate_t multiple;
    rate_t rate;
    rate_t down;
    rate_t up;
  } side_t;

  // One restoring remainder step: shift in one numerator bit, subtract if it fits.
  function automatic rate_t mod_step(rate_t rem, logic nbit, rate_t den);
    logic [RATE_BITS:0] trial;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      mod_step = rate_t'(trial - {1'b0, den});
    end else begin
      mod_step = trial[RATE_BITS-1:0];
    end
  endfunction

  // True when a is more than 1 Hz above b.
  function automatic logic beyond_one(rate_t a, rate_t b);
    beyond_one = ({1'b0, a} > ({1'b0, b} + {{RATE_BITS{1'b0}}, 1'b1}));
  endfunction

endpackage

### hw/rtl/srs_front.sv
// Front end: normalises the ideal rate and clamps it to the device range.
module srs_front (
  input  srs_pkg::in_t   req,
  input  srs_pkg::cfg_t  cfg,
  output srs_pkg::side_t side
);

  srs_pkg::rate_t ideal_a;
  srs_pkg::rate_t ideal_b;
  srs_pkg::rate_t ideal_c;
  srs_pkg::rate_t rate_lo;

  always_comb begin
    ideal_a = req.target_hz;
    if (req.target_hz == '0) begin
      ideal_a = (req.least_hz != '0) ? req.least_hz : req.useful_ceiling_hz;
    end
    ideal_b = ideal_a;
    if (req.useful_ceiling_hz != '0 && ideal_a > req.useful_ceiling_hz) begin
      ideal_b = req.useful_ceiling_hz;
    end
    ideal_c = ideal_b;
    if (req.least_hz != '0 && ideal_b < req.least_hz) begin
      ideal_c = req.least_hz;
    end
    rate_lo = (ideal_c < cfg.floor_hz) ? cfg.floor_hz : ideal_c;

    side          = '0;
    side.caps_bad = (cfg.ceiling_hz == '0) || (cfg.ceiling_hz < cfg.floor_hz);
    side.ideal    = ideal_c;
    side.minimum  = req.least_hz;
    side.ceil_use = req.useful_ceiling_hz;
    side.multiple = req.preferred_multiple_hz;
    side.rate     = (rate_lo > cfg.ceiling_hz) ? cfg.ceiling_hz : rate_lo;
  end

endmodule

### hw/rtl/srs_queue.sv
// Short request queue between the front and back ends.
module srs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srs_pkg::side_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output srs_pkg::side_t pop_data
);

  localparam int PTR_BITS = (srs_pkg::QUEUE_DEPTH > 1) ? $clog2(srs_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(srs_pkg::QUEUE_DEPTH + 1);

  srs_pkg::side_t        mem [srs_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full      = (count_r == CNT_BITS'(srs_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(srs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(srs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(srs_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

### hw/rtl/srs_mod.sv
// Pipelined remainder unit, one numerator bit per stage, carrying request state.
module srs_mod (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  srs_pkg::rate_t num,
  input  srs_pkg::rate_t den,
  input  srs_pkg::side_t side_i,
  output logic           out_valid,
  output srs_pkg::rate_t rem,
  output srs_pkg::side_t side_o
);

  localparam int N = srs_pkg::DIV_STAGES;
  localparam int MSB = srs_pkg::RATE_BITS - 1;

  logic           vld_r  [N];
  srs_pkg::rate_t rem_r  [N];
  srs_pkg::rate_t num_r  [N];
  srs_pkg::rate_t den_r  [N];
  srs_pkg::side_t side_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= srs_pkg::mod_step('0, num[MSB], den);
      num_r[0]  <= num << 1;
      den_r[0]  <= den;
      side_r[0] <= side_i;
      for (int k = 1; k < N; k++) begin
        rem_r[k]  <= srs_pkg::mod_step(rem_r[k-1], num_r[k-1][MSB], den_r[k-1]);
        num_r[k]  <= num_r[k-1] << 1;
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign rem       = rem_r[N-1];
  assign side_o    = side_r[N-1];

endmodule

### hw/rtl/srs_back.sv
// Back end: grid snap, multiple search, grid checks and classification.
module srs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  srs_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  srs_pkg::side_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output srs_pkg::out_t  out_data
);

  logic           adv;
  logic           a_vld, b_vld, c_vld;
  srs_pkg::rate_t a_rem, b_rem, c_rem, d_rem;
  srs_pkg::side_t a_side, b_side, c_side;
  srs_pkg::rate_t a_num, c_num, d_num;

  logic           p1_vld_r, p2_vld_r, p3_vld_r, out_valid_r;
  srs_pkg::side_t p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  srs_pkg::out_t  out_r, out_nxt;

  srs_pkg::rate_t snap;
  srs_pkg::rate_t soft_cap;
  logic [srs_pkg::RATE_BITS:0] up_sum;
  logic           grid_down, grid_up, take_down, take_up;

  // Advance the whole back end when the output register is free or being taken.
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  assign a_num = (cfg.step_hz != '0 && q_data.rate > cfg.floor_hz) ?
                 q_data.rate - cfg.floor_hz : '0;

  srs_mod u_mod_snap (
    .clk, .rst_n, .en(adv), .in_valid(q_valid), .num(a_num), .den(cfg.step_hz),
    .side_i(q_data), .out_valid(a_vld), .rem(a_rem), .side_o(a_side)
  );

  always_comb begin
    p1_nxt = a_side;
    snap   = (cfg.step_hz != '0) ? a_side.rate - a_rem : a_side.rate;
    p1_nxt.rate = (snap == '0) ? cfg.ceiling_hz : snap;
  end

  srs_mod u_mod_mult (
    .clk, .rst_n, .en(adv), .in_valid(p1_vld_r), .num(p1_r.rate), .den(p1_r.multiple),
    .side_i(p1_r), .out_valid(b_vld), .rem(b_rem), .side_o(b_side)
  );

  always_comb begin
    p2_nxt      = b_side;
    p2_nxt.down = b_side.rate - b_rem;
    up_sum      = {1'b0, p2_nxt.down} + {1'b0, b_side.multiple};
    if (b_rem == '0) begin
      p2_nxt.up    = b_side.rate;
      p2_nxt.up_ok = 1'b1;
    end else begin
      p2_nxt.up    = up_sum[srs_pkg::RATE_BITS-1:0];
      p2_nxt.up_ok = !up_sum[srs_pkg::RATE_BITS];
    end
  end

  assign c_num = (p2_r.down >= cfg.floor_hz) ? p2_r.down - cfg.floor_hz : '0;
  assign d_num = (p2_r.up >= cfg.floor_hz) ? p2_r.up - cfg.floor_hz : '0;

  srs_mod u_mod_grid_down (
    .clk, .rst_n, .en(adv), .in_valid(p2_vld_r), .num(c_num), .den(cfg.step_hz),
    .side_i(p2_r), .out_valid(c_vld), .rem(c_rem), .side_o(c_side)
  );

  srs_mod u_mod_grid_up (
    .clk, .rst_n, .en(adv), .in_valid(p2_vld_r), .num(d_num), .den(cfg.step_hz),
    .side_i(p2_r), .out_valid(), .rem(d_rem), .side_o()
  );

  always_comb begin
    p3_nxt    = c_side;
    soft_cap  = (c_side.ceil_use != '0) ? c_side.ceil_use : cfg.ceiling_hz;
    grid_down = (cfg.step_hz == '0) || (c_side.down >= cfg.floor_hz && c_rem == '0);
    grid_up   = (cfg.step_hz == '0) || (c_side.up >= cfg.floor_hz && d_rem == '0);
    take_down = c_side.down != '0 && c_side.down >= cfg.floor_hz &&
                !srs_pkg::beyond_one(c_side.minimum, c_side.down) && grid_down;
    take_up   = c_side.up_ok && c_side.up != '0 && c_side.up >= c_side.rate &&
                c_side.up >= cfg.floor_hz && c_side.up <= cfg.ceiling_hz &&
                !srs_pkg::beyond_one(c_side.up, soft_cap) && grid_up;
    if (c_side.multiple != '0) begin
      if (take_down) begin
        p3_nxt.rate = c_side.down;
      end else if (take_up) begin
        p3_nxt.rate = c_side.up;
      end
    end
  end

  always_comb begin
    out_nxt.chosen_hz = p3_r.rate;
    if (p3_r.caps_bad) begin
      out_nxt.chosen_hz = p3_r.ideal;
      out_nxt.outcome   = srs_pkg::OUT_CAPS_BAD;
    end else if (p3_r.minimum != '0 && srs_pkg::beyond_one(p3_r.minimum, p3_r.rate)) begin
      out_nxt.outcome = srs_pkg::OUT_BELOW_MIN;
    end else if (srs_pkg::beyond_one(p3_r.ideal, p3_r.rate)) begin
      out_nxt.outcome = srs_pkg::OUT_REDUCED;
    end else if (srs_pkg::beyond_one(p3_r.rate, p3_r.ideal)) begin
      out_nxt.outcome = srs_pkg::OUT_RAISED;
    end else begin
      out_nxt.outcome = srs_pkg::OUT_IDEAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      p3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r    <= a_vld;
      p2_vld_r    <= b_vld;
      p3_vld_r    <= c_vld;
      out_valid_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/sample_rate_selector.sv
// Top level of the receive sample rate selector.
//
//   channel  direction  handshake          payload
//   in_      input      valid / stall      srs_pkg::in_t
//   out_     output     valid / stall      srs_pkg::out_t
//   cfg_     input      valid / ready      index, 32-bit data
//
// One request per cycle sustained while the output is not stalled; requests pass through
// the three chained bit-per-stage remainder pipelines (snap, multiple, grid).
// A two-entry queue parts the front end from the back end; a stalled output
// freezes the back end and the front keeps taking requests until the queue fills.
// Reset clears the configuration registers, queue pointers and valid bits.
module sample_rate_selector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  srs_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output srs_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [srs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  srs_pkg::rate_t                      cfg_data
);

  srs_pkg::cfg_t  cfg_r;
  srs_pkg::side_t front_side;
  srs_pkg::side_t q_data;
  logic           q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srs_pkg::CFG_FLOOR:   cfg_r.floor_hz   <= cfg_data;
        srs_pkg::CFG_CEILING: cfg_r.ceiling_hz <= cfg_data;
        srs_pkg::CFG_STEP:    cfg_r.step_hz    <= cfg_data;
        default: ;
      endcase
    end
  end

  srs_front u_front (
    .req(in_data), .cfg(cfg_r), .side(front_side)
  );

  assign in_stall = q_full;

  srs_queue u_queue (
    .clk, .rst_n, .push(in_valid), .push_data(front_side), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_data)
  );

  srs_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .out_data
  );

endmodule

### dv/testbench.sv
// Self-checking testbench of the receive sample rate selector.
module testbench;

  localparam int LATENCY   = 3 * srs_pkg::DIV_STAGES + 4;
  localparam int WD_LIMIT  = 20000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  srs_pkg::in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  srs_pkg::out_t  out_data;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [srs_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  srs_pkg::rate_t cfg_data = '0;

  sample_rate_selector dut (.*);

  always #5 clk = ~clk;

  // Mirror of the device range and grid.
  srs_pkg::rate_t dev_floor, dev_ceiling, dev_step;
  srs_pkg::out_t  rate_expq[$];
  int    fail_count;
  int    send_idle_pct, recv_idle_pct;
  bit    hold_recv;
  int    idle_cycles;

  function automatic logic on_grid(logic [63:0] v);
    if (dev_step == 0) return 1'b1;
    if (v < dev_floor) return 1'b0;
    return ((v - dev_floor) % dev_step) == 0;
  endfunction

  function automatic logic above_one(logic [63:0] a, logic [63:0] b);
    return a > b && (a - b) > 1;
  endfunction

  function automatic srs_pkg::out_t select_rate(srs_pkg::in_t r);
    logic [63:0] ideal, minv, cuse, mult, lo, hi, rate, soft_cap, q, down, up;
    logic up_ok;
    srs_pkg::out_t res;
    ideal = r.target_hz; minv = r.least_hz; cuse = r.useful_ceiling_hz;
    mult = r.preferred_multiple_hz; lo = dev_floor; hi = dev_ceiling;
    if (ideal == 0) ideal = (minv != 0) ? minv : cuse;
    if (cuse != 0 && ideal > cuse) ideal = cuse;
    if (minv != 0 && ideal < minv) ideal = minv;
    if (hi == 0 || hi < lo) begin
      res.chosen_hz = ideal[31:0];
      res.outcome = srs_pkg::OUT_CAPS_BAD;
      return res;
    end
    rate = ideal;
    if (rate < lo) rate = lo;
    if (rate > hi) rate = hi;
    if (dev_step != 0) begin
      if (rate <= lo) rate = lo;
      else rate = lo + ((rate - lo) / dev_step) * dev_step;
    end
    if (rate == 0) rate = hi;
    if (mult != 0) begin
      soft_cap = (cuse != 0) ? cuse : hi;
      q = rate / mult;
      down = q * mult;
      up = 0;
      up_ok = 1'b1;
      if (down == rate) up = rate;
      else if ((q + 1) > 64'hFFFF_FFFF / mult) up_ok = 1'b0;
      else up = (q + 1) * mult;
      if (down != 0 && down >= lo && !above_one(minv, down) && on_grid(down)) rate = down;
      else if (up_ok && up != 0 && up >= rate && up >= lo && up <= hi &&
               !above_one(up, soft_cap) && on_grid(up)) rate = up;
    end
    res.chosen_hz = rate[31:0];
    if (minv != 0 && above_one(minv, rate)) res.outcome = srs_pkg::OUT_BELOW_MIN;
    else if (above_one(ideal, rate)) res.outcome = srs_pkg::OUT_REDUCED;
    else if (above_one(rate, ideal)) res.outcome = srs_pkg::OUT_RAISED;
    else res.outcome = srs_pkg::OUT_IDEAL;
    return res;
  endfunction

  // Receiver: random stall, optional long hold-off, and result check.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rate_expq.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        srs_pkg::out_t e;
        e = rate_expq.pop_front();
        if (out_data.chosen_hz !== e.chosen_hz)
          $display("%0t chosen_hz expected %0d actual %0d", $time, e.chosen_hz,
                   out_data.chosen_hz);
        if (out_data.outcome !== e.outcome)
          $display("%0t outcome expected %0d actual %0d", $time, e.outcome,
                   out_data.outcome);
        if (out_data !== e) fail_count++;
      end
    end
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no accepted request, result or configuration write.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Leave valid up after the request is taken; the next request replaces it, or an idle pause or drain drops it.
  task automatic send_request(srs_pkg::in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rate_expq.push_back(select_rate(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rate_expq.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(srs_pkg::cfg_idx_t idx, srs_pkg::rate_t v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      srs_pkg::CFG_FLOOR:   dev_floor = v;
      srs_pkg::CFG_CEILING: dev_ceiling = v;
      default:              dev_step = v;
    endcase
  endtask

  task automatic set_device(srs_pkg::rate_t lo, srs_pkg::rate_t hi, srs_pkg::rate_t st);
    drain();
    write_reg(srs_pkg::CFG_FLOOR, lo);
    write_reg(srs_pkg::CFG_CEILING, hi);
    write_reg(srs_pkg::CFG_STEP, st);
    cfg_valid <= 1'b0;
  endtask

  function automatic srs_pkg::rate_t rand_rate();
    case ($urandom_range(5))
      0: return $urandom_range(3);
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom;
      default: return $urandom_range(200000, 1000);
    endcase
  endfunction

  function automatic srs_pkg::in_t rand_request();
    srs_pkg::in_t r;
    r.target_hz = rand_rate();
    r.least_hz = ($urandom_range(2) == 0) ? 0 : rand_rate();
    r.useful_ceiling_hz = ($urandom_range(2) == 0) ? 0 : rand_rate();
    case ($urandom_range(3))
      0: r.preferred_multiple_hz = 0;
      1: r.preferred_multiple_hz = $urandom;
      default: r.preferred_multiple_hz = $urandom_range(5000, 1);
    endcase
    return r;
  endfunction

  task automatic test_caps_unusable();
    // Reset state: ceiling 0, so every request is returned as its ideal.
    send_request('{0, 0, 0, 0});
    send_request('{0, 500, 0, 0});
    send_request('{0, 0, 700, 3});
    send_request('{900, 100, 600, 0});
    send_request('{50, 100, 0, 0});
    send_request('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    set_device(1000, 999, 0);  // floor above ceiling
    send_request('{5000, 0, 0, 0});
  endtask

  task automatic test_directed();
    set_device(1000, 48000, 250);
    send_request('{44100, 0, 0, 0});      // snapped down onto the grid
    send_request('{10, 0, 0, 0});         // raised to the floor
    send_request('{90000, 0, 0, 0});      // reduced to the ceiling
    send_request('{30000, 0, 0, 7000});   // moved down to a multiple
    send_request('{3000, 2999, 0, 7000}); // up to a multiple
    send_request('{3000, 2000, 0, 32'hFFFF_FFFF}); // up candidate above the ceiling
    send_request('{20000, 50000, 0, 0});  // below minimum
    send_request('{20001, 0, 0, 0});      // within 1 Hz tolerance
    set_device(0, 32'hFFFF_FFFF, 0);
    send_request('{0, 0, 0, 0});          // nothing after snapping: ceiling used
    send_request('{32'hFFFF_FFFF, 0, 0, 2});
    send_request('{32'hFFFF_FFFE, 0, 32'hFFFF_FFFF, 3});
    set_device(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request('{1, 0, 0, 5});
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_request());
  endtask

  task automatic test_backpressure();
    set_device(8000, 192000, 1000);
    // More requests than the pipeline holds, so the input stalls during the hold.
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      test_random(150);
    join
    drain();  // sender pauses until everything is back
    test_random(40);
  endtask

  initial begin
    fail_count = 0;
    hold_recv = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    dev_floor = 0; dev_ceiling = 0; dev_step = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_caps_unusable();
    test_directed();
    send_idle_pct = 14; recv_idle_pct = 88;
    set_device(0, 32'hFFFF_FFFF, 0);
    test_random(200);
    set_device(44100, 192000, 100);
    test_random(200);
    send_idle_pct = 88; recv_idle_pct = 14;
    set_device($urandom_range(50000), $urandom_range(300000, 60000), $urandom_range(5000));
    test_random(200);
    set_device($urandom, $urandom, $urandom_range(3));
    test_random(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    set_device(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random(150);
    set_device(0, 1, 1);
    test_random(150);
    drain();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
